FILE: hw/rtl/pngunf_pkg.sv
// ----------------------------------------------------------------------------
// pngunf_pkg: shared types and helpers for PNG scanline reconstruction
// Filter type codes, register indexes and the Paeth predictor.
// ----------------------------------------------------------------------------
package pngunf_pkg;

	// Filter type carried in the first byte of every scanline
	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filter_t;

	// Register indexes on the configuration port (paddr[2])
	localparam logic REG_LINE  = 1'b0;
	localparam logic REG_PIXEL = 1'b1;

	localparam int CFG_ADDR_W = 3;
	localparam int LINE_CFG_W = 14;
	localparam int PIX_CFG_W  = 3;

	// Paeth predictor: pick the neighbor closest to a + b - c
	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] pc;
		da = $signed({3'b000, b}) - $signed({3'b000, c});
		db = $signed({3'b000, a}) - $signed({3'b000, c});
		dc = da + db;
		pa = (da < 0) ? 10'(-da) : 10'(da);
		pb = (db < 0) ? 10'(-db) : 10'(db);
		pc = (dc < 0) ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

endpackage

FILE: hw/rtl/png_scanline_unfilter_core.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core: PNG filter reconstruction, one byte per cycle unless stalled
// Undoes None, Sub, Up, Average and Paeth filtering on an inflated scanline
// stream, using a line buffer for the row above.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Width  Contents
// s_axis    in         8+1    tdata = data_byte, tuser = image_start
// m_axis    out        8+1+1  tdata = pixel_byte, tlast = row_end, tuser = bad_filter
// apb       in/out     32     reg 0 bytes_per_line (0x0), reg 1 bytes_per_pixel (0x4)
//
// One item per cycle sustained: an input register feeds the reconstruction
// logic, whose result is registered in the output register.
// The line buffer read for the next column is registered ahead of its use; in the
// cycle after a register write an item in the input register waits for it.
// The input side stalls when both registers are full and m_axis_tready is low,
// or during that wait. Reset clears control state; the line buffer is not cleared.
module png_scanline_unfilter_core #(
	parameter int MAX_LINE_BYTES  = 8192,
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] image_start
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] pixel_byte
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,   // [0] bad_filter
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [pngunf_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
	localparam int LW = $clog2(MAX_LINE_BYTES + 1);
	localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// configuration registers
	logic [pngunf_pkg::LINE_CFG_W-1:0] line_cfg_q;
	logic [pngunf_pkg::PIX_CFG_W-1:0]  pix_cfg_q;
	logic cfg_we;

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       start_s1;

	// reconstruction state
	pngunf_pkg::filter_t filter_q, filter_d;
	logic [AW-1:0] col_q, col_d;
	logic          await_q, await_d;
	logic          first_q, first_d;
	logic          halted_q, halted_d;
	logic [7:0]    left_q [MAX_PIXEL_BYTES];
	logic [7:0]    left_d [MAX_PIXEL_BYTES];
	logic [7:0]    ul_q [MAX_PIXEL_BYTES];
	logic [7:0]    ul_d [MAX_PIXEL_BYTES];

	// line buffer
	logic [7:0]    prior_mem [MAX_LINE_BYTES];
	logic [7:0]    rd_q;
	logic          rd_ok_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic [AW-1:0] col_cur;

	// output register
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;
	logic       out_bad_q;

	// datapath
	logic [LW-1:0] line_eff;
	logic [PW-1:0] pix_idx;
	logic          out_space;
	logic          go;
	logic          res_valid;
	logic [7:0]    res_data;
	logic          res_last;
	logic          res_bad;
	logic          halted_eff;
	logic          await_eff;
	logic          first_eff;
	logic [7:0]    nb_a;
	logic [7:0]    nb_b;
	logic [7:0]    nb_c;
	logic [7:0]    pred;
	logic [8:0]    avg_sum;
	logic [7:0]    recon;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cfg_q <= pngunf_pkg::LINE_CFG_W'(1);
			pix_cfg_q  <= pngunf_pkg::PIX_CFG_W'(3);
		end else if (cfg_we) begin
			case (paddr[2])
				pngunf_pkg::REG_LINE:  line_cfg_q <= pwdata[pngunf_pkg::LINE_CFG_W-1:0];
				pngunf_pkg::REG_PIXEL: pix_cfg_q  <= pwdata[pngunf_pkg::PIX_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pngunf_pkg::REG_LINE:  prdata = 32'(line_cfg_q);
			pngunf_pkg::REG_PIXEL: prdata = 32'(pix_cfg_q);
			default:               prdata = '0;
		endcase
	end

	// clamp register values to the supported range
	always_comb begin
		if (line_cfg_q == '0) begin
			line_eff = LW'(1);
		end else if (32'(line_cfg_q) > 32'(MAX_LINE_BYTES)) begin
			line_eff = LW'(MAX_LINE_BYTES);
		end else begin
			line_eff = LW'(line_cfg_q);
		end
		if (pix_cfg_q == '0) begin
			pix_idx = '0;
		end else if (32'(pix_cfg_q) > 32'(MAX_PIXEL_BYTES)) begin
			pix_idx = PW'(MAX_PIXEL_BYTES - 1);
		end else begin
			pix_idx = PW'(pix_cfg_q - 3'd1);
		end
	end

	// ------------------------------------------------------------------
	// handshake: advance the input register when the result has room
	// ------------------------------------------------------------------
	assign out_space     = !out_valid_q || m_axis_tready;
	assign go            = valid_s1 && rd_ok_q && out_space;
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// ------------------------------------------------------------------
	// reconstruction of the item in the input register
	// ------------------------------------------------------------------
	always_comb begin
		halted_eff = halted_q && !start_s1;
		await_eff  = await_q || start_s1;
		first_eff  = first_q || start_s1;

		// current column, pulled back inside a shortened line
		col_cur = (LW'(col_q) >= line_eff) ? AW'(line_eff - LW'(1)) : col_q;

		nb_a = left_q[pix_idx];
		nb_c = ul_q[pix_idx];
		nb_b = first_eff ? 8'd0 : rd_q;
		avg_sum = 9'(nb_a) + 9'(nb_b);

		case (filter_q)
			pngunf_pkg::FLT_SUB:   pred = nb_a;
			pngunf_pkg::FLT_UP:    pred = nb_b;
			pngunf_pkg::FLT_AVG:   pred = avg_sum[8:1];
			pngunf_pkg::FLT_PAETH: pred = pngunf_pkg::paeth_pick(nb_a, nb_b, nb_c);
			default:               pred = 8'd0;
		endcase
		recon = data_s1 + pred;

		filter_d  = filter_q;
		col_d     = col_q;
		await_d   = await_q;
		first_d   = first_q;
		halted_d  = halted_q;
		left_d    = left_q;
		ul_d      = ul_q;
		res_valid = 1'b0;
		res_data  = recon;
		res_last  = 1'b0;
		res_bad   = 1'b0;
		mem_we    = 1'b0;

		if (go) begin
			halted_d = halted_eff;
			await_d  = await_eff;
			first_d  = first_eff;
			if (start_s1) begin
				col_d = '0;
			end
			if (!halted_eff) begin
				if (await_eff) begin
					// filter byte: clear neighbors, check the type
					for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
						left_d[k] = 8'd0;
						ul_d[k]   = 8'd0;
					end
					col_d = '0;
					if (data_s1 > 8'(pngunf_pkg::FLT_PAETH)) begin
						halted_d  = 1'b1;
						res_valid = 1'b1;
						res_data  = 8'd0;
						res_bad   = 1'b1;
					end else begin
						filter_d = pngunf_pkg::filter_t'(data_s1[2:0]);
						await_d  = 1'b0;
					end
				end else begin
					// data byte: shift neighbors, store into the line buffer
					mem_we    = 1'b1;
					res_valid = 1'b1;
					for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
						left_d[k] = left_q[k-1];
						ul_d[k]   = ul_q[k-1];
					end
					left_d[0] = recon;
					ul_d[0]   = nb_b;
					if (LW'(col_cur) + LW'(1) >= line_eff) begin
						res_last = 1'b1;
						col_d    = '0;
						await_d  = 1'b1;
						first_d  = 1'b0;
					end else begin
						col_d = col_cur + AW'(1);
					end
				end
			end
		end

		// prefetch the line buffer for the next column
		rd_addr = (LW'(col_d) >= line_eff) ? AW'(line_eff - LW'(1)) : col_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= pngunf_pkg::FLT_NONE;
			col_q    <= '0;
			await_q  <= 1'b1;
			first_q  <= 1'b1;
			halted_q <= 1'b0;
			rd_ok_q  <= 1'b0;
			for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
				left_q[k] <= 8'd0;
				ul_q[k]   <= 8'd0;
			end
		end else begin
			filter_q <= filter_d;
			col_q    <= col_d;
			await_q  <= await_d;
			first_q  <= first_d;
			halted_q <= halted_d;
			// a register write may move the prefetch address
			rd_ok_q  <= !cfg_we;
			left_q   <= left_d;
			ul_q     <= ul_d;
		end
	end

	// line buffer: write the new byte, read ahead with write bypass
	always_ff @(posedge clk) begin
		if (mem_we) begin
			prior_mem[col_cur] <= recon;
		end
		if (mem_we && (col_cur == rd_addr)) begin
			rd_q <= recon;
		end else begin
			rd_q <= prior_mem[rd_addr];
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_space) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_space && res_valid) begin
			out_data_q <= res_data;
			out_last_q <= res_last;
			out_bad_q  <= res_bad;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_bad_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 8'd0) && !m_axis_tlast)
		else $error("error item carries data or row end");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		go && res_valid && res_bad |=> halted_q && m_axis_tvalid)
		else $error("bad filter did not halt the block");

	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		go && res_valid && res_last |=> await_q && (col_q == '0) && !first_q)
		else $error("row end did not rearm for the filter byte");

endmodule
